>>> hdl/i2c_light_sensor_poller_macros.svh
// Assertion macros shared by the checker of the light sensor poller.
`ifndef I2C_LIGHT_SENSOR_POLLER_MACROS_SVH
`define I2C_LIGHT_SENSOR_POLLER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ILSP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ILSP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ilsp_pkg.sv
// Types and constants of the I2C light sensor poller.
package ilsp_pkg;

    typedef enum logic [4:0] {
        PH_IDLE      = 5'd0,
        PH_START1    = 5'd1,
        PH_ADDR_W    = 5'd2,
        PH_CMD       = 5'd3,
        PH_STOP1     = 5'd4,
        PH_CONV_WAIT = 5'd5,
        PH_START2    = 5'd6,
        PH_ADDR_R    = 5'd7,
        PH_READ_MSB  = 5'd8,
        PH_READ_LSB  = 5'd9,
        PH_STOP2     = 5'd10,
        PH_REPEAT    = 5'd11,
        PH_STOP_ERR  = 5'd12
    } phase_t;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_COMMAND   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONV_WAIT      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_WAIT    = 2'd3;

    localparam logic [6:0]  RST_DEVICE_ADDRESS = 7'h23;
    localparam logic [7:0]  RST_MODE_COMMAND   = 8'h10;
    localparam logic [19:0] RST_CONV_WAIT      = 20'd36000;
    localparam logic [19:0] RST_REPEAT_WAIT    = 20'd600000;

    // Five sixths as a fixed-point fraction with 20 fractional bits, set just above the exact value.
    localparam int unsigned LUX_FRAC_W = 20;
    localparam logic [LUX_FRAC_W-1:0] LUX_RECIP = 20'd873815;

    typedef struct packed {
        logic [6:0]  device_address;
        logic [7:0]  mode_command;
        logic [19:0] conv_wait;
        logic [19:0] repeat_wait;
    } cfg_t;

    typedef struct packed {
        phase_t      phase;
        logic [1:0]  quarter;
        logic [3:0]  bit_index;
        logic [7:0]  shift_byte;
        logic [7:0]  high_byte;
        logic [19:0] wait_count;
        logic [15:0] lux;
    } poll_state_t;

    typedef struct packed {
        logic scl;
        logic sda_out;
        logic sda_oe;
        logic new_sample;
        logic ack_error;
        logic bus_busy;
    } poll_result_t;

endpackage

>>> hdl/ilsp_lux.sv
// Conversion of the raw sensor reading to lux: raw times five sixths, truncated.
module ilsp_lux
    import ilsp_pkg::*;
(
    input  logic [15:0] raw,
    output logic [15:0] lux
);

    logic [15+LUX_FRAC_W:0] product;

    assign product = raw * LUX_RECIP;
    assign lux     = product[15+LUX_FRAC_W:LUX_FRAC_W];

endmodule

>>> hdl/ilsp_step.sv
// Next-state and bus-level logic of the poller for one quarter-bit tick.
module ilsp_step
    import ilsp_pkg::*;
(
    input  cfg_t         cfg,
    input  poll_state_t  cur,
    input  logic         sda,
    output poll_state_t  nxt,
    output poll_result_t res
);

    logic        last;
    logic [1:0]  q_inc;
    logic [15:0] lux_conv;
    logic [19:0] wait_limit;

    assign last       = (cur.quarter == 2'd3);
    assign q_inc      = cur.quarter + 2'd1;
    assign wait_limit = (cur.phase == PH_CONV_WAIT) ? cfg.conv_wait : cfg.repeat_wait;

    ilsp_lux u_lux (
        .raw (16'({cur.high_byte, cur.shift_byte})),
        .lux (lux_conv)
    );

    always_comb begin
        nxt            = cur;
        res.scl        = 1'b1;
        res.sda_out    = 1'b1;
        res.sda_oe     = 1'b1;
        res.new_sample = 1'b0;
        res.ack_error  = 1'b0;
        res.bus_busy   = 1'b1;
        unique case (cur.phase)
            PH_START1, PH_START2: begin
                res.sda_out = ~cur.quarter[1];
                if (last) begin
                    nxt.shift_byte = {cfg.device_address, cur.phase == PH_START2};
                    nxt.bit_index  = 4'd0;
                    nxt.phase      = (cur.phase == PH_START1) ? PH_ADDR_W : PH_ADDR_R;
                end
                nxt.quarter = q_inc;
            end
            PH_STOP1, PH_STOP2, PH_STOP_ERR: begin
                res.scl     = (cur.quarter != 2'd0);
                res.sda_out = cur.quarter[1];
                if (last) begin
                    nxt.wait_count = 20'd0;
                    if (cur.phase == PH_STOP1) begin
                        nxt.phase = PH_CONV_WAIT;
                    end else begin
                        if (cur.phase == PH_STOP2) begin
                            nxt.lux        = lux_conv;
                            res.new_sample = 1'b1;
                        end
                        nxt.phase = PH_REPEAT;
                    end
                end
                nxt.quarter = q_inc;
            end
            PH_ADDR_W, PH_CMD, PH_ADDR_R: begin
                res.scl = cur.quarter[1];
                if (!cur.bit_index[3]) begin
                    res.sda_out = cur.shift_byte[3'd7 - cur.bit_index[2:0]];
                end else begin
                    res.sda_oe  = 1'b0;
                    res.sda_out = 1'b0;
                end
                if (last) begin
                    if (!cur.bit_index[3]) begin
                        nxt.bit_index = cur.bit_index + 4'd1;
                    end else if (sda) begin
                        res.ack_error = 1'b1;
                        nxt.phase     = PH_STOP_ERR;
                    end else begin
                        nxt.bit_index = 4'd0;
                        if (cur.phase == PH_ADDR_W) begin
                            nxt.shift_byte = cfg.mode_command;
                            nxt.phase      = PH_CMD;
                        end else if (cur.phase == PH_CMD) begin
                            nxt.phase = PH_STOP1;
                        end else begin
                            nxt.shift_byte = 8'd0;
                            nxt.phase      = PH_READ_MSB;
                        end
                    end
                end
                nxt.quarter = q_inc;
            end
            PH_READ_MSB, PH_READ_LSB: begin
                res.scl = cur.quarter[1];
                if (!cur.bit_index[3]) begin
                    res.sda_oe  = 1'b0;
                    res.sda_out = 1'b0;
                end else begin
                    res.sda_out = (cur.phase == PH_READ_LSB);
                end
                if (last) begin
                    if (!cur.bit_index[3]) begin
                        nxt.shift_byte = {cur.shift_byte[6:0], sda};
                        nxt.bit_index  = cur.bit_index + 4'd1;
                    end else if (cur.phase == PH_READ_MSB) begin
                        nxt.high_byte  = cur.shift_byte;
                        nxt.shift_byte = 8'd0;
                        nxt.bit_index  = 4'd0;
                        nxt.phase      = PH_READ_LSB;
                    end else begin
                        nxt.bit_index = 4'd0;
                        nxt.phase     = PH_STOP2;
                    end
                end
                nxt.quarter = q_inc;
            end
            PH_CONV_WAIT, PH_REPEAT: begin
                res.bus_busy = 1'b0;
                if (cur.wait_count >= wait_limit) begin
                    nxt.phase      = (cur.phase == PH_CONV_WAIT) ? PH_START2 : PH_IDLE;
                    nxt.quarter    = 2'd0;
                    nxt.wait_count = 20'd0;
                end else begin
                    nxt.wait_count = cur.wait_count + 20'd1;
                end
            end
            default: begin
                res.bus_busy  = 1'b0;
                nxt.phase     = PH_START1;
                nxt.quarter   = 2'd0;
                nxt.bit_index = 4'd0;
            end
        endcase
    end

endmodule

>>> hdl/i2c_light_sensor_poller.sv
// Top level of the self-polling I2C light sensor master.
// Each accepted word is one quarter-bit tick carrying the sampled SDA level, and each
// tick yields exactly one result word in the following cycle: the SCL and SDA levels to drive,
// the SDA drive enable, the stored lux value and the sample and error pulses. A tick is
// accepted in every cycle while the result register is empty or being emptied, so the
// sustained rate is one tick per clock; while a finished word waits unaccepted, no new
// tick is taken in. The lux conversion multiplies by a fixed-point
// reciprocal inside the single step stage. Configuration writes take effect at the next
// clock edge and should only be made while no result is pending.
module i2c_light_sensor_poller
    import ilsp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_sda_level,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_scl_level,
    output logic                  m_sda_out_level,
    output logic                  m_sda_drive_enable,
    output logic [15:0]           m_lux_value,
    output logic                  m_new_sample,
    output logic                  m_ack_error,
    output logic                  m_bus_busy
);

    cfg_t         cfg_reg;
    poll_state_t  state_reg;
    poll_state_t  state_next;
    poll_result_t step_res;
    poll_result_t res_reg;
    logic [15:0]  lux_reg;
    logic         m_valid_reg;
    logic         accept;

    assign s_ready = ~m_valid_reg | m_ready;
    assign accept  = s_valid & s_ready;

    ilsp_step u_step (
        .cfg (cfg_reg),
        .cur (state_reg),
        .sda (s_sda_level),
        .nxt (state_next),
        .res (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.device_address <= RST_DEVICE_ADDRESS;
            cfg_reg.mode_command   <= RST_MODE_COMMAND;
            cfg_reg.conv_wait      <= RST_CONV_WAIT;
            cfg_reg.repeat_wait    <= RST_REPEAT_WAIT;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DEVICE_ADDRESS: cfg_reg.device_address <= cfg_wdata[6:0];
                CFG_MODE_COMMAND:   cfg_reg.mode_command   <= cfg_wdata[7:0];
                CFG_CONV_WAIT:      cfg_reg.conv_wait      <= cfg_wdata[19:0];
                CFG_REPEAT_WAIT:    cfg_reg.repeat_wait    <= cfg_wdata[19:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase      <= PH_IDLE;
            state_reg.quarter    <= 2'd0;
            state_reg.bit_index  <= 4'd0;
            state_reg.shift_byte <= 8'd0;
            state_reg.high_byte  <= 8'd0;
            state_reg.wait_count <= 20'd0;
            state_reg.lux        <= 16'd0;
            m_valid_reg          <= 1'b0;
        end else begin
            if (accept) begin
                state_reg <= state_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= step_res;
            lux_reg <= state_next.lux;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_scl_level        = res_reg.scl;
    assign m_sda_out_level    = res_reg.sda_out;
    assign m_sda_drive_enable = res_reg.sda_oe;
    assign m_lux_value        = lux_reg;
    assign m_new_sample       = res_reg.new_sample;
    assign m_ack_error        = res_reg.ack_error;
    assign m_bus_busy         = res_reg.bus_busy;

endmodule

>>> hdl/ilsp_checker.sv
// Port-level checks of the light sensor poller and their binding to the top level.
`include "i2c_light_sensor_poller_macros.svh"

module ilsp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_scl_level,
    input logic        m_sda_out_level,
    input logic        m_sda_drive_enable,
    input logic [15:0] m_lux_value,
    input logic        m_new_sample,
    input logic        m_ack_error,
    input logic        m_bus_busy
);

    `ILSP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_lux_value) && $stable(m_scl_level), "stalled result word changed")

    `ILSP_ASSERT_NOW(a_pulse_excl, aclk, aresetn, m_valid,
        !(m_new_sample && m_ack_error), "new sample and acknowledge error in one word")

    `ILSP_ASSERT_NOW(a_released_low, aclk, aresetn, m_valid && !m_sda_drive_enable,
        !m_sda_out_level, "released SDA shows a high drive level")

    `ILSP_ASSERT_NOW(a_idle_lines, aclk, aresetn, m_valid && !m_bus_busy,
        m_scl_level && m_sda_out_level && m_sda_drive_enable,
        "bus lines not high while not busy")

endmodule

bind i2c_light_sensor_poller ilsp_checker u_ilsp_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_scl_level        (m_scl_level),
    .m_sda_out_level    (m_sda_out_level),
    .m_sda_drive_enable (m_sda_drive_enable),
    .m_lux_value        (m_lux_value),
    .m_new_sample       (m_new_sample),
    .m_ack_error        (m_ack_error),
    .m_bus_busy         (m_bus_busy)
);
